/* sv/dftt_pkg.sv */
package dftt_pkg;

   localparam int unsigned IDX_MAX_W = 10;
   localparam int unsigned CNT_MAX_W = 11;
   localparam logic [15:0] DNS_PORT = 16'd53;
   localparam logic [15:0] TIMEOUT_RESET = 16'd60;

   localparam logic [2:0] MODE_LOOKUP = 3'd0;
   localparam logic [2:0] MODE_UPDATE = 3'd1;
   localparam logic [2:0] MODE_TICK   = 3'd2;
   localparam logic [2:0] MODE_STATS  = 3'd3;
   localparam logic [2:0] MODE_SWEEP  = 3'd4;
   localparam logic [2:0] MODE_CLEAR  = 3'd5;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_ADDED     = 3'd1;
   localparam logic [2:0] ST_NOT_DNS   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   typedef struct packed {
      logic [2:0]  mode;
      logic        is_ipv4_udp;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] udp_sport;
      logic [15:0] udp_dport;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [15:0] cli_port;
      logic [15:0] srv_port;
      logic [31:0] created_time;
      logic [6:0]  removed_count;
      logic [6:0]  entry_total;
      logic [6:0]  live_entries;
   } rsp_type;

   // request traveling down the row of cells
   typedef struct packed {
      logic                 active;
      logic [2:0]           mode;
      logic                 dns;
      logic [63:0]          key_addr;
      logic [31:0]          key_ports;
      logic                 fwd_hit;
      logic                 any_hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic [63:0]          hit_addr;
      logic [31:0]          hit_ports;
      logic [31:0]          hit_created;
      logic                 free_found;
      logic [IDX_MAX_W-1:0] free_idx;
      logic [CNT_MAX_W-1:0] cnt;
   } wave_type;

   typedef struct packed {
      logic                 touch;
      logic                 insert;
      logic [IDX_MAX_W-1:0] idx;
      logic [63:0]          addr;
      logic [31:0]          ports;
      logic [31:0]          now;
   } wr_type;

endpackage

/* sv/dftt_cell.sv */
module dftt_cell
   import dftt_pkg::*;
#(
   parameter int unsigned IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  wave_type    wave_i,
   output wave_type    wave_o,
   input  logic [31:0] now,
   input  logic [15:0] timeout,
   input  wr_type      wr
);

   logic        valid_ff, valid_in;
   logic [63:0] addr_ff, addr_in;
   logic [31:0] ports_ff, ports_in;
   logic [31:0] created_ff, created_in;
   logic [31:0] last_ff, last_in;
   wave_type    wave_ff, wave_in;
   logic        fwd_m, rev_m, expired;
   logic [31:0] age;

   assign age = now - last_ff;
   assign expired = age > {16'd0, timeout};
   assign fwd_m = valid_ff && addr_ff == wave_i.key_addr && ports_ff == wave_i.key_ports;
   assign rev_m = valid_ff
                  && addr_ff == {wave_i.key_addr[31:0], wave_i.key_addr[63:32]}
                  && ports_ff == {wave_i.key_ports[15:0], wave_i.key_ports[31:16]};

   always_comb begin
      wave_in = wave_i;
      valid_in = valid_ff;
      addr_in = addr_ff;
      ports_in = ports_ff;
      created_in = created_ff;
      last_in = last_ff;
      if (wave_i.active) begin
         case (wave_i.mode)
            MODE_LOOKUP, MODE_UPDATE: begin
               if (wave_i.dns) begin
                  // first forward match beats any reverse match
                  if (fwd_m && !wave_i.fwd_hit) begin
                     wave_in.fwd_hit = 1'b1;
                     wave_in.any_hit = 1'b1;
                     wave_in.hit_idx = IDX_MAX_W'(IDX);
                     wave_in.hit_addr = addr_ff;
                     wave_in.hit_ports = ports_ff;
                     wave_in.hit_created = created_ff;
                  end else if (rev_m && !wave_i.any_hit) begin
                     wave_in.any_hit = 1'b1;
                     wave_in.hit_idx = IDX_MAX_W'(IDX);
                     wave_in.hit_addr = addr_ff;
                     wave_in.hit_ports = ports_ff;
                     wave_in.hit_created = created_ff;
                  end
                  if (!valid_ff && !wave_i.free_found) begin
                     wave_in.free_found = 1'b1;
                     wave_in.free_idx = IDX_MAX_W'(IDX);
                  end
               end
            end
            MODE_STATS: begin
               if (valid_ff && !expired) wave_in.cnt = wave_i.cnt + 1'b1;
            end
            MODE_SWEEP: begin
               if (valid_ff && expired) begin
                  wave_in.cnt = wave_i.cnt + 1'b1;
                  valid_in = 1'b0;
               end
            end
            MODE_CLEAR: begin
               if (valid_ff) wave_in.cnt = wave_i.cnt + 1'b1;
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (wr.idx == IDX_MAX_W'(IDX)) begin
         if (wr.touch) last_in = wr.now;
         if (wr.insert) begin
            valid_in = 1'b1;
            addr_in = wr.addr;
            ports_in = wr.ports;
            created_in = wr.now;
            last_in = wr.now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff <= wave_in;
      end
      addr_ff <= addr_in;
      ports_ff <= ports_in;
      created_ff <= created_in;
      last_ff <= last_in;
   end

   assign wave_o = wave_ff;

endmodule

/* sv/dns_flow_tracking_table_top.sv */
// DNS flow table with idle aging.
// Requests: drive req_data and raise start; the request is taken at a clock
// edge where start is high and busy is low. busy stays high until the result.
// Results: rsp_valid is high for exactly one cycle with rsp_data; the receiver
// cannot hold a result off, so it must sample it in that cycle.
// Timeout register: csr_wdata is written when csr_valid and csr_ready are high;
// csr_ready is always high. Write it only while the block is idle.
// Pipeline: the accept edge loads the entry stage, the request then walks the
// row of CAPACITY entry cells one cell per cycle, and the result stage then
// registers the result. One request is in flight at a time; a new start is
// taken in the rsp_valid cycle.
// Table writes (refresh, insert) land at the edge that raises rsp_valid.
// Reset: all entries invalid, seconds counter and entry count zero, timeout 60,
// no request in flight.
module dns_flow_tracking_table_top
   import dftt_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   logic              busy_ff, busy_in;
   logic [15:0]       timeout_ff;
   logic [31:0]       now_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   wave_type          head_ff, head_in;
   wave_type          chain [CAPACITY+1];
   wave_type          t;
   wr_type            wr;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;
   logic              accept, pkt;
   logic [63:0]       e_addr;
   logic [31:0]       e_ports, e_created;

   assign accept = start && !busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      head_in = '0;
      head_in.active = accept;
      head_in.mode = req_data.mode;
      head_in.dns = req_data.is_ipv4_udp
                    && (req_data.udp_sport == DNS_PORT || req_data.udp_dport == DNS_PORT);
      head_in.key_addr = {req_data.src_addr, req_data.dst_addr};
      head_in.key_ports = {req_data.udp_sport, req_data.udp_dport};
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      dftt_cell #(.IDX(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .wave_i (chain[g]),
         .wave_o (chain[g+1]),
         .now    (now_ff),
         .timeout(timeout_ff),
         .wr     (wr)
      );
   end

   assign t = chain[CAPACITY];
   assign pkt = t.active && t.dns && (t.mode == MODE_LOOKUP || t.mode == MODE_UPDATE);

   always_comb begin
      wr = '0;
      wr.touch = pkt && t.any_hit;
      wr.insert = pkt && t.mode == MODE_UPDATE && !t.any_hit && t.free_found;
      wr.idx = t.any_hit ? t.hit_idx : t.free_idx;
      wr.addr = t.key_addr;
      wr.ports = t.key_ports;
      wr.now = now_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (wr.insert) count_in = count_ff + 1'b1;
      else if (t.active && t.mode == MODE_SWEEP) count_in = count_ff - t.cnt[CNT_W-1:0];
      else if (t.active && t.mode == MODE_CLEAR) count_in = '0;
   end

   always_comb begin
      if (t.any_hit) begin
         e_addr = t.hit_addr;
         e_ports = t.hit_ports;
         e_created = t.hit_created;
      end else begin
         e_addr = t.key_addr;
         e_ports = t.key_ports;
         e_created = now_ff;
      end
      rsp_in = '0;
      rsp_in.status = ST_DONE;
      case (t.mode)
         MODE_LOOKUP, MODE_UPDATE: begin
            if (!t.dns) rsp_in.status = ST_NOT_DNS;
            else if (t.any_hit || wr.insert) begin
               rsp_in.status = t.any_hit ? ST_FOUND : ST_ADDED;
               // the side using the dns port is the server
               if (e_ports[31:16] == DNS_PORT) begin
                  rsp_in.client_addr = e_addr[31:0];
                  rsp_in.server_addr = e_addr[63:32];
                  rsp_in.cli_port = e_ports[15:0];
                  rsp_in.srv_port = e_ports[31:16];
               end else begin
                  rsp_in.client_addr = e_addr[63:32];
                  rsp_in.server_addr = e_addr[31:0];
                  rsp_in.cli_port = e_ports[31:16];
                  rsp_in.srv_port = e_ports[15:0];
               end
               rsp_in.created_time = e_created;
            end else if (t.mode == MODE_LOOKUP) rsp_in.status = ST_NOT_FOUND;
            else rsp_in.status = ST_FULL;
         end
         MODE_STATS: rsp_in.live_entries = t.cnt[6:0];
         MODE_SWEEP, MODE_CLEAR: rsp_in.removed_count = t.cnt[6:0];
         default: begin
         end
      endcase
      rsp_in.entry_total = 7'(count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (t.active) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
         now_ff <= '0;
         count_ff <= '0;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (csr_valid) timeout_ff <= csr_wdata;
         if (accept && req_data.mode == MODE_TICK) now_ff <= now_ff + 1'b1;
         count_ff <= count_in;
         head_ff <= head_in;
         rsp_valid_ff <= t.active;
      end
      if (t.active) rsp_ff <= rsp_in;
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* sv/dftt_checker.sv */
module dftt_checker
   import dftt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a taken request keeps the block busy and gives no result next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request not held busy");

   // the result cycle frees the block
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result outside a busy period");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_DONE)
      else $error("bad status");

endmodule

bind dns_flow_tracking_table_top dftt_checker u_dftt_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
